// ----- design/scpd_pkg.sv -----
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared constants and types for the sync/checksum packet deframer.
// ----------------------------------------------------------------------------
package scpd_pkg;

   localparam int FRAME_LENGTH = 67;
   localparam int PAYLOAD_LEN  = FRAME_LENGTH - 3;

   localparam int BYTE_W       = 8;
   localparam int BYTE_INDEX_W = 6;

   localparam int FILL_W    = $clog2(FRAME_LENGTH);
   localparam int POS_W     = $clog2(FRAME_LENGTH);
   localparam int ADDR_W    = $clog2(2 * FRAME_LENGTH);
   localparam int MEM_DEPTH = 1 << ADDR_W;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

   typedef logic [BYTE_W-1:0]       data_byte_type;
   typedef logic [BYTE_INDEX_W-1:0] byte_index_type;

   // each buffer entry keeps its byte together with the byte received before it
   typedef struct packed {
      data_byte_type prev_byte;
      data_byte_type cur_byte;
   } entry_type;

   typedef struct packed {
      data_byte_type  payload_byte;
      byte_index_type byte_index;
      logic           last;
   } rsp_item_type;

   typedef struct packed {
      byte_index_type byte_index;
      logic           last;
   } rsp_tag_type;

endpackage

// ----- design/scpd_if.sv -----
// ----------------------------------------------------------------------------
// scpd_req_if / scpd_rsp_if
// Valid/ready channels for received bytes and deframed payload bytes.
// ----------------------------------------------------------------------------
interface scpd_req_if;
   import scpd_pkg::*;

   logic          valid;
   logic          ready;
   data_byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface scpd_rsp_if;
   import scpd_pkg::*;

   logic           valid;
   logic           ready;
   data_byte_type  payload_byte;
   byte_index_type byte_index;
   logic           last;

   modport source (output valid, output payload_byte, output byte_index, output last,
                   input ready);
   modport sink (input valid, input payload_byte, input byte_index, input last,
                 output ready);
endinterface

// ----- design/sync_checksum_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// sync_checksum_packet_deframer
// Finds 0xAA 0x55 framed packets with an 8-bit additive checksum in a byte
// stream and emits their payload bytes.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. The byte window lives in a circular
// buffer of MEM_DEPTH entries (256 at the default frame length), each entry
// holding a byte and its predecessor, so one read of the entry after the
// window head yields both sync bytes and the byte to drop on a resync.
// A frame that passes the sync and checksum test is read back out of the
// buffer at one payload byte per cycle while the output queue has room
// (64 transfers at the default length), each byte fetched into a register
// and then into a two-entry output queue. Input keeps flowing during
// readout; it stalls only when a byte would close the next window while
// the previous frame is still being read from the buffer.
// ----------------------------------------------------------------------------
module sync_checksum_packet_deframer (
   input logic        clock,
   input logic        reset,
   scpd_req_if.sink   req_chan,
   scpd_rsp_if.source rsp_chan
);
   import scpd_pkg::*;

   entry_type          window_mem [MEM_DEPTH];

   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   data_byte_type      sum_ff, sum_in;
   data_byte_type      prev_ff;
   entry_type          rd_a_ff;

   logic               drain_active_ff, drain_active_in;
   logic [ADDR_W-1:0]  drain_addr_ff, drain_addr_in;
   logic [POS_W-1:0]   drain_pos_ff, drain_pos_in;

   logic               rd_vld_ff;
   data_byte_type      rd_b_ff;
   rsp_tag_type        rd_tag_ff;

   rsp_item_type       fifo_ff [2];
   logic               fifo_wr_ff, fifo_rd_ff;
   logic [1:0]         fifo_cnt_ff, fifo_cnt_in;

   logic               req_fire, window_full, sync_ok, frame_ok;
   logic [ADDR_W-1:0]  tail, rd_a_addr;
   logic               pop, issue, drain_last;
   logic [1:0]         occ_after_pop;
   rsp_item_type       out_item;

   assign window_full = fill_ff == FILL_W'(FRAME_LENGTH - 1);
   assign req_chan.ready = !(drain_active_ff && window_full);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign sync_ok  = (rd_a_ff.prev_byte == SYNC_FIRST) && (rd_a_ff.cur_byte == SYNC_SECOND);
   assign frame_ok = req_fire && window_full && sync_ok && (sum_ff == req_chan.rx_byte);
   assign tail     = head_ff + ADDR_W'(fill_ff);

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (req_fire) begin
         if (!window_full) begin
            fill_in = fill_ff + FILL_W'(1);
            sum_in  = sum_ff + req_chan.rx_byte;
         end else if (frame_ok) begin
            head_in = tail + ADDR_W'(1);
            fill_in = '0;
            sum_in  = '0;
         end else begin
            head_in = head_ff + ADDR_W'(1);
            sum_in  = sum_ff + req_chan.rx_byte - rd_a_ff.prev_byte;
         end
      end
   end

   assign rd_a_addr = head_in + ADDR_W'(1);

   // readout of an accepted frame
   assign pop           = rsp_chan.valid && rsp_chan.ready;
   assign occ_after_pop = fifo_cnt_ff + {1'b0, rd_vld_ff} - {1'b0, pop};
   assign issue         = drain_active_ff && (occ_after_pop < 2'd2);
   assign drain_last    = drain_pos_ff == POS_W'(PAYLOAD_LEN - 1);

   always_comb begin
      drain_active_in = drain_active_ff;
      drain_addr_in   = drain_addr_ff;
      drain_pos_in    = drain_pos_ff;
      if (frame_ok) begin
         drain_active_in = 1'b1;
         drain_addr_in   = head_ff + ADDR_W'(2);
         drain_pos_in    = '0;
      end else if (issue) begin
         drain_addr_in = drain_addr_ff + ADDR_W'(1);
         drain_pos_in  = drain_pos_ff + POS_W'(1);
         if (drain_last) begin
            drain_active_in = 1'b0;
         end
      end
   end

   assign fifo_cnt_in = fifo_cnt_ff + {1'b0, rd_vld_ff} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         window_mem[tail] <= '{prev_byte: prev_ff, cur_byte: req_chan.rx_byte};
         prev_ff          <= req_chan.rx_byte;
      end
      rd_a_ff <= window_mem[rd_a_addr];
      if (issue) begin
         rd_b_ff   <= window_mem[drain_addr_ff].cur_byte;
         rd_tag_ff <= '{byte_index: BYTE_INDEX_W'(drain_pos_ff), last: drain_last};
      end
      if (rd_vld_ff) begin
         fifo_ff[fifo_wr_ff] <= '{payload_byte: rd_b_ff, byte_index: rd_tag_ff.byte_index,
                                  last: rd_tag_ff.last};
      end
      drain_addr_ff <= drain_addr_in;
      drain_pos_ff  <= drain_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         fill_ff         <= '0;
         sum_ff          <= '0;
         drain_active_ff <= 1'b0;
         rd_vld_ff       <= 1'b0;
         fifo_wr_ff      <= 1'b0;
         fifo_rd_ff      <= 1'b0;
         fifo_cnt_ff     <= '0;
      end else begin
         head_ff         <= head_in;
         fill_ff         <= fill_in;
         sum_ff          <= sum_in;
         drain_active_ff <= drain_active_in;
         rd_vld_ff       <= issue;
         fifo_cnt_ff     <= fifo_cnt_in;
         if (rd_vld_ff) begin
            fifo_wr_ff <= !fifo_wr_ff;
         end
         if (pop) begin
            fifo_rd_ff <= !fifo_rd_ff;
         end
      end
   end

   assign out_item              = fifo_ff[fifo_rd_ff];
   assign rsp_chan.valid        = fifo_cnt_ff != 2'd0;
   assign rsp_chan.payload_byte = out_item.payload_byte;
   assign rsp_chan.byte_index   = out_item.byte_index;
   assign rsp_chan.last         = out_item.last;

   // a new frame never starts while the previous one is still read from the buffer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      frame_ok |-> !drain_active_ff)
      else $error("frame accepted during readout");

   // output queue never overflows
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff != 2'd3 && !(rd_vld_ff && !pop && fifo_cnt_ff == 2'd2))
      else $error("output queue overflow");

   // readout ends right after the final payload byte is fetched
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      issue && drain_last |=> !drain_active_ff && rd_vld_ff && rd_tag_ff.last)
      else $error("readout did not end on last byte");

   // window fill never passes one short of a frame
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FRAME_LENGTH - 1))
      else $error("window fill out of range");

endmodule
